/* rtl/sorted_table_predecessor_search_defines.svh */
// Assertion macros shared by the search block.
`ifndef SORTED_TABLE_PREDECESSOR_SEARCH_DEFINES_SVH
`define SORTED_TABLE_PREDECESSOR_SEARCH_DEFINES_SVH

// Check on every edge outside reset.
`define STPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every edge, reset included.
`define STPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/stps_pkg.sv */
`timescale 1ns / 1ps

package stps_pkg;

  localparam int unsigned CountW = 13;
  localparam int unsigned IndexW = 12;
  localparam int unsigned EntryW = 32;
  localparam logic [EntryW-1:0] FlagMask = 32'hFFFF_FFFC;

  localparam logic ModeLoad   = 1'b0;
  localparam logic ModeSearch = 1'b1;

  typedef enum logic [1:0] {
    RD_LO,
    RD_MID,
    RD_LO_M1
  } stps_rd_sel_e;

  typedef struct packed {
    logic         write;
    logic         start;
    logic         step;
    logic         back;
    logic         cap_found;
    logic         cap_empty;
    stps_rd_sel_e rd_sel;
  } stps_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic lo_lt_hi;
    logic back_needed;
    logic out_free;
  } stps_status_t;

endpackage

/* rtl/sorted_table_predecessor_search.sv */
`timescale 1ns / 1ps
// Sequence: a load is written as it is accepted; a search takes a read and a compare per
//   binary step (at most ceil(log2(count)), 12 at 4096 entries), one read of the final
//   entry and one more with a step back, then waits for a free result register.
// Flow: one request at a time, each step sharing the single registered read port of the RAM.
// Reset: asynchronous, active low; clears table_count, search bounds and the
//   result valid flag. Table contents are undefined until written.

module sorted_table_predecessor_search #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration: table_count
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [stps_pkg::CountW-1:0]    cfg_table_count_i,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic [stps_pkg::IndexW-1:0]    write_index_i,
  input  logic [stps_pkg::EntryW-1:0]    entry_value_i,
  input  logic [stps_pkg::EntryW-1:0]    search_address_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [stps_pkg::IndexW-1:0]    found_index_o,
  output logic [stps_pkg::EntryW-1:0]    found_entry_o,
  output logic                           table_empty_o
);
  import stps_pkg::*;

  stps_cmd_t    cmd;
  stps_status_t status;

  // Config writes must arrive only while idle; the block does not enforce this and always takes them.
  assign cfg_ready_o = 1'b1;

  // Controller: accept a request in idle, walk the binary search, step back
  // one entry if the lower bound lies above the key, then hand off the result.
  stps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: table RAM, search bounds, key, count register and the output
  // register that parts the result side from the search loop.
  stps_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_table_count_i (cfg_table_count_i),
    .write_index_i     (write_index_i),
    .entry_value_i     (entry_value_i),
    .search_address_i  (search_address_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .found_index_o     (found_index_o),
    .found_entry_o     (found_entry_o),
    .table_empty_o     (table_empty_o)
  );

endmodule

/* rtl/stps_ctrl.sv */
`timescale 1ns / 1ps

module stps_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  mode_i,
  output logic                  in_stall_o,
  input  stps_pkg::stps_status_t status_i,
  output stps_pkg::stps_cmd_t    cmd_o
);
  import stps_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SRCH_CMP,
    ST_FIN_CMP,
    ST_BACK_CMP,
    ST_EMPTY
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.rd_sel     = RD_LO;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (mode_i == ModeSearch)) begin
          cmd_o.start = 1'b1;
          state_d     = status_i.count_zero ? ST_EMPTY : ST_SRCH;
        end else if (accept) begin
          cmd_o.write = 1'b1;
        end
      end
      ST_SRCH: begin
        if (status_i.lo_lt_hi) begin
          cmd_o.rd_sel = RD_MID;
          state_d      = ST_SRCH_CMP;
        end else begin
          state_d = ST_FIN_CMP;
        end
      end
      ST_SRCH_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_SRCH;
      end
      ST_FIN_CMP: begin
        if (status_i.back_needed) begin
          cmd_o.back   = 1'b1;
          cmd_o.rd_sel = RD_LO_M1;
          state_d      = ST_BACK_CMP;
        end else if (status_i.out_free) begin
          cmd_o.cap_found = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_BACK_CMP: begin
        if (status_i.out_free) begin
          cmd_o.cap_found = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o.cap_empty = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/stps_dpath.sv */
`timescale 1ns / 1ps
`include "sorted_table_predecessor_search_defines.svh"

module stps_dpath #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stps_pkg::CountW-1:0]    cfg_table_count_i,
  input  logic [stps_pkg::IndexW-1:0]    write_index_i,
  input  logic [stps_pkg::EntryW-1:0]    entry_value_i,
  input  logic [stps_pkg::EntryW-1:0]    search_address_i,
  input  stps_pkg::stps_cmd_t            cmd_i,
  output stps_pkg::stps_status_t         status_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [stps_pkg::IndexW-1:0]    found_index_o,
  output logic [stps_pkg::EntryW-1:0]    found_entry_o,
  output logic                           table_empty_o
);
  import stps_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  logic [EntryW-1:0] mem_q [TABLE_DEPTH];
  logic [EntryW-1:0] rd_data_q;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  logic [31:0]       widx_ext;

  logic [CountW-1:0] table_count_q;
  logic [CntW-1:0]   cnt_sat;
  logic [CntW-1:0]   cnt_m1;

  logic [EntryW-1:0] key_q;
  logic [IdxW-1:0]   lo_q, lo_d;
  logic [IdxW-1:0]   hi_q, hi_d;
  logic [IdxW:0]     mid_sum;
  logic [IdxW-1:0]   mid;
  logic [EntryW-1:0] entry_addr;
  logic              key_le;
  logic [31:0]       lo_ext;

  logic              out_valid_q;
  logic [IndexW-1:0] found_index_q;
  logic [EntryW-1:0] found_entry_q;
  logic              table_empty_q;
  logic              out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_count_q <= '0;
    end else if (cfg_we_i) begin
      table_count_q <= cfg_table_count_i;
    end
  end

  // Saturate the count at the table depth.
  always_comb begin
    if (32'(table_count_q) > 32'(TABLE_DEPTH)) begin
      cnt_sat = CntW'(TABLE_DEPTH);
    end else begin
      cnt_sat = CntW'(table_count_q);
    end
    cnt_m1 = cnt_sat - CntW'(1);
  end

  assign widx_ext = 32'(write_index_i);
  assign wr_en    = cmd_i.write && (widx_ext < 32'(TABLE_DEPTH));

  assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = mid_sum[IdxW:1];
  assign entry_addr = rd_data_q & FlagMask;
  assign key_le     = (key_q <= entry_addr);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_MID:   rd_addr = mid;
      RD_LO_M1: rd_addr = lo_q - IdxW'(1);
      default:  rd_addr = lo_q;
    endcase
  end

  // Table storage: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[widx_ext[IdxW-1:0]] <= entry_value_i;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.start) begin
      lo_d = '0;
      hi_d = cnt_m1[IdxW-1:0];
    end else if (cmd_i.step) begin
      if (key_le) begin
        hi_d = mid;
      end else begin
        lo_d = mid + IdxW'(1);
      end
    end else if (cmd_i.back) begin
      lo_d = lo_q - IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= search_address_i;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.count_zero  = (table_count_q == '0);
  assign status_o.lo_lt_hi    = (lo_q < hi_q);
  assign status_o.back_needed = (lo_q != '0) && (entry_addr > key_q);
  assign status_o.out_free    = out_free;

  assign lo_ext = 32'(lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.cap_found || cmd_i.cap_empty) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_found) begin
      found_index_q <= lo_ext[IndexW-1:0];
      found_entry_q <= rd_data_q;
      table_empty_q <= 1'b0;
    end else if (cmd_i.cap_empty) begin
      found_index_q <= '0;
      found_entry_q <= '0;
      table_empty_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_index_o = found_index_q;
  assign found_entry_o = found_entry_q;
  assign table_empty_o = table_empty_q;

  `STPS_ASSERT(a_lo_le_hi, lo_q <= hi_q, "search bounds crossed")
  `STPS_ASSERT(a_cap_when_free, (cmd_i.cap_found || cmd_i.cap_empty) |-> out_free, "result overwritten")
  `STPS_ASSERT(a_empty_zero, (out_valid_q && table_empty_q) |-> (found_index_q == '0 && found_entry_q == '0), "empty result carries data")
  `STPS_ASSERT_ALWAYS(a_rst_no_valid, !rst_ni |=> !out_valid_q, "result valid in reset")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import stps_pkg::*;

  localparam int unsigned TableDepth = 4096;
  // Typical ROM base in the address map; used as a directed entry and key.
  localparam logic [EntryW-1:0] RomBase = 32'hB000_0000;
  // Drain pause at the end of settle; generous room for any trailing load to finish.
  localparam int unsigned DrainCycles = 64;
  // Longest quiet stretch of a correct run is a full-depth search under a long
  // result stall, or a drain pause; this is many times that.
  localparam int unsigned WatchdogLimit = 5000;

  typedef struct packed {
    logic              mode;
    logic [IndexW-1:0] index;
    logic [EntryW-1:0] entry;
    logic [EntryW-1:0] addr;
  } request_t;

  typedef struct packed {
    logic [IndexW-1:0] index;
    logic [EntryW-1:0] entry;
    logic              empty;
  } lookup_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CountW-1:0] cfg_table_count_i = '0;

  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              mode_i = ModeLoad;
  logic [IndexW-1:0] write_index_i = '0;
  logic [EntryW-1:0] entry_value_i = '0;
  logic [EntryW-1:0] search_address_i = '0;

  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [IndexW-1:0] found_index_o;
  logic [EntryW-1:0] found_entry_o;
  logic              table_empty_o;

  sorted_table_predecessor_search uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_table_count_i(cfg_table_count_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .write_index_i    (write_index_i),
    .entry_value_i    (entry_value_i),
    .search_address_i (search_address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .found_index_o    (found_index_o),
    .found_entry_o    (found_entry_o),
    .table_empty_o    (table_empty_o)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the block state, updated only as requests are accepted.
  logic [EntryW-1:0] mirror_entries [TableDepth];
  logic [CountW-1:0] table_count_q = '0;
  // Intended table contents, updated as requests are queued; used to aim keys.
  logic [EntryW-1:0] plan_entries [TableDepth];

  request_t    request_queue [$];
  lookup_t     pending_lookups [$];
  int unsigned pending_reqs = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  request_t    next_req;
  lookup_t     want;

  // Lower-bound search over the valid span, then step back one entry when the
  // hit lies above the key.
  function automatic lookup_t predict_lookup(logic [EntryW-1:0] key);
    int unsigned span, lo, hi, mid;
    lookup_t     res;
    res = '0;
    span = (table_count_q > TableDepth) ? TableDepth : table_count_q;
    if (span == 0) begin
      res.empty = 1'b1;
      return res;
    end
    lo = 0;
    hi = span - 1;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (key <= (mirror_entries[mid] & FlagMask)) hi = mid;
      else lo = mid + 1;
    end
    if (lo > 0 && (mirror_entries[lo] & FlagMask) > key) lo = lo - 1;
    res.index = lo[IndexW-1:0];
    res.entry = mirror_entries[lo];
    return res;
  endfunction

  // Request driver: hold a stalled request, otherwise advance or idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (mode_i == ModeLoad) mirror_entries[write_index_i] = entry_value_i;
        else pending_lookups.push_back(predict_lookup(search_address_i));
        pending_reqs--;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_req = request_queue.pop_front();
          in_valid_i       <= 1'b1;
          mode_i           <= next_req.mode;
          write_index_i    <= next_req.index;
          entry_value_i    <= next_req.entry;
          search_address_i <= next_req.addr;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result stall at the current receiver idle rate.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Result monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result index=%0d entry=%h empty=%b", $time,
                 found_index_o, found_entry_o, table_empty_o);
        mismatch_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (found_index_o !== want.index) begin
          $display("%0t: found_index expected %0d actual %0d", $time, want.index,
                   found_index_o);
          mismatch_count++;
        end
        if (found_entry_o !== want.entry) begin
          $display("%0t: found_entry expected %h actual %h", $time, want.entry,
                   found_entry_o);
          mismatch_count++;
        end
        if (table_empty_o !== want.empty) begin
          $display("%0t: table_empty expected %b actual %b", $time, want.empty,
                   table_empty_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: count cycles without any handshake on any channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o === 1'b1)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_request(request_t req);
    pending_reqs++;
    request_queue.push_back(req);
  endtask

  task automatic push_load(int unsigned idx, logic [EntryW-1:0] val);
    request_t req;
    req.mode  = ModeLoad;
    req.index = idx[IndexW-1:0];
    req.entry = val;
    req.addr  = $urandom();
    plan_entries[idx] = val;
    push_request(req);
  endtask

  task automatic push_search(logic [EntryW-1:0] key);
    request_t req;
    req.mode  = ModeSearch;
    req.index = $urandom();
    req.entry = $urandom();
    req.addr  = key;
    push_request(req);
  endtask

  // Wait until every request is accepted and every result is back, then let
  // any trailing load finish inside the block.
  task automatic settle();
    while (pending_reqs != 0 || pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_table_count(logic [CountW-1:0] count);
    settle();
    @(posedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_table_count_i <= count;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i   <= 1'b0;
    table_count_q = count;
  endtask

  // Write entries 0..n-1 in address order, with random flag bits and a few
  // duplicate addresses.
  task automatic fill_sorted(int unsigned n);
    longint unsigned at;
    longint unsigned stride;
    logic [EntryW-1:0] a;
    at = $urandom_range(0, 255) * 4;
    stride = 64'hFFFF_FFF0 / n;
    for (int unsigned i = 0; i < n; i++) begin
      a = (at > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : at[31:0];
      push_load(i, (a & FlagMask) | $urandom_range(0, 3));
      if ($urandom_range(0, 15) != 0) at += $urandom_range(0, stride[31:0]);
    end
  endtask

  // Write every entry that a full-depth search for the lowest or the highest
  // key visits; those two paths do not depend on the stored values.
  task automatic fill_edge_paths();
    int unsigned lo, hi, mid;
    lo = 0;
    hi = TableDepth - 1;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      push_load(mid, $urandom());
      hi = mid;
    end
    push_load(0, $urandom());
    lo = 0;
    hi = TableDepth - 1;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      push_load(mid, $urandom());
      lo = mid + 1;
    end
    push_load(TableDepth - 1, $urandom());
  endtask

  // Full-depth searches with keys whose path stays on the written entries.
  task automatic edge_searches(int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 1) != 0) push_search(32'hFFFF_FFFC | $urandom_range(1, 3));
      else push_search(32'h0);
    end
  endtask

  // Mostly searches aimed at stored addresses, with some noise loads.
  task automatic random_searches(int unsigned n, int unsigned span);
    int unsigned pick;
    logic [EntryW-1:0] base;
    logic [EntryW-1:0] key;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        if (span > 0 && $urandom_range(0, 3) == 0)
          push_load($urandom_range(0, span - 1), $urandom());
        else if (span < TableDepth)
          push_load($urandom_range(span, TableDepth - 1), $urandom());
      end
      pick = (span > 0) ? $urandom_range(0, span - 1) : 0;
      base = (span > 0) ? (plan_entries[pick] & FlagMask) : $urandom();
      case ($urandom_range(0, 8))
        0: key = $urandom();
        1: key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        2, 3: key = base | $urandom_range(0, 3);
        4: key = base - 1;
        5: key = base + 4;
        6: key = base + $urandom_range(1, 1000);
        7: key = base - $urandom_range(1, 1000);
        default: key = base;
      endcase
      push_search(key);
    end
  endtask

  initial begin
    int unsigned count;
    send_idle_pct = 13;
    recv_idle_pct = 72;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table straight after reset.
    push_search(32'h0);
    push_search(32'hFFFF_FFFF);

    // Small sorted table: flag bits set, duplicate address, extreme values.
    push_load(0, 32'h0000_0013);
    push_load(1, 32'h1000_0001);
    push_load(2, 32'h8000_0000);
    push_load(3, RomBase | 32'h2);
    push_load(4, RomBase | 32'h1);
    push_load(5, 32'hC000_0000);
    push_load(6, 32'hF000_0003);
    push_load(7, 32'hFFFF_FFFF);
    push_load(TableDepth - 1, 32'h0);
    set_table_count(8);
    push_search(32'h0);          // below the first entry: no step back
    push_search(32'h10);         // exact match on the first entry
    push_search(32'h11);         // between entries: step back
    push_search(RomBase);        // duplicate address: first of the pair
    push_search(RomBase + 1);    // key with low bits set
    push_search(32'hFFFF_FFFC);  // exact match on the last entry
    push_search(32'hFFFF_FFFF);  // above every entry
    push_search(32'h7FFF_FFFF);

    // Break the order and search through the unsorted table.
    push_load(2, 32'h0);
    push_search(32'h8000_0000);
    push_search(32'h5000_0000);

    // Single entry.
    set_table_count(1);
    push_search(32'h0);
    push_search(32'hFFFF_FFFF);

    set_table_count(23);
    fill_sorted(23);
    random_searches(50, 23);

    set_table_count(TableDepth);
    fill_edge_paths();
    edge_searches(20);

    send_idle_pct = 72;
    recv_idle_pct = 13;
    // Counts above the depth saturate; this one sets every count bit.
    set_table_count(8191);
    edge_searches(20);
    set_table_count(TableDepth + 1);
    edge_searches(10);
    count = $urandom_range(2, 64);
    set_table_count(count);
    fill_sorted(count);
    random_searches(40, count);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_table_count(0);
    random_searches(20, 0);
    count = $urandom_range(40, 80);
    set_table_count(count);
    fill_sorted(count);
    random_searches(40, count);
    set_table_count(2);
    random_searches(20, 2);

    settle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
